@@ rtl/pms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types, codes and saturation helpers of the particle motion step.
// ----------------------------------------------------------------------------
package pms_pkg;

  localparam int unsigned CoordBits = 20;

  typedef logic signed [CoordBits-1:0] coord_t;

  localparam coord_t CoordMax = coord_t'((2 ** (CoordBits - 1)) - 1);
  localparam coord_t CoordMin = coord_t'(-(2 ** (CoordBits - 1)));

  typedef enum logic [1:0] {
    REQ_STEP     = 2'd0,
    REQ_LOAD_POS = 2'd1,
    REQ_LOAD_VEL = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_WRAP    = 2'd0,
    MODE_BOUNCE  = 2'd1,
    MODE_RESPAWN = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EV_INSIDE  = 2'd0,
    EV_WRAP    = 2'd1,
    EV_BOUNCE  = 2'd2,
    EV_RESPAWN = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    CFG_BOX_LOW   = 3'd0,
    CFG_BOX_HIGH  = 3'd1,
    CFG_BOUNDS    = 3'd2,
    CFG_DRAG      = 3'd3,
    CFG_SPEED     = 3'd4,
    CFG_INV_MASS  = 3'd5,
    CFG_TIME_STEP = 3'd6,
    CFG_UNUSED    = 3'd7
  } cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ACC,
    ST_DV,
    ST_VADD,
    ST_DRAG,
    ST_DRAGW,
    ST_SQ,
    ST_SQACC,
    ST_SQRT,
    ST_SCMUL,
    ST_DIVS,
    ST_DIV,
    ST_POS,
    ST_PADD,
    ST_BND,
    ST_RSP,
    ST_RSPW,
    ST_OUT
  } state_e;

  function automatic coord_t sat_coord(input logic signed [31:0] v);
    coord_t r;
    if (v > 32'(CoordMax)) begin
      r = CoordMax;
    end else if (v < 32'(CoordMin)) begin
      r = CoordMin;
    end else begin
      r = v[CoordBits-1:0];
    end
    return r;
  endfunction

  function automatic coord_t neg_sat(input coord_t v);
    coord_t r;
    if (v == CoordMin) begin
      r = CoordMax;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

@@ rtl/pms_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_isqrt
// Bit-serial integer square root of a 40-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module pms_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] radicand_i,
  output logic        done_o,
  output logic [19:0] root_o
);

  logic [39:0] x_q, x_d;
  logic [22:0] rem_q, rem_d;
  logic [19:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  logic [22:0] rem_n;
  logic [22:0] trial;

  always_comb begin
    rem_n  = {rem_q[20:0], x_q[39:38]};
    trial  = {1'b0, root_q, 2'b01};
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = 5'd19;
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d = {x_q[37:0], 2'b00};
      if (rem_n >= trial) begin
        rem_d  = rem_n - trial;
        root_d = {root_q[18:0], 1'b1};
      end else begin
        rem_d  = rem_n;
        root_d = {root_q[18:0], 1'b0};
      end
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ rtl/pms_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_div
// Restoring divider, 40-bit dividend by a nonzero 20-bit divisor, one
// quotient bit a cycle.
// ----------------------------------------------------------------------------
module pms_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] dividend_i,
  input  logic [19:0] divisor_i,
  output logic        done_o,
  output logic [39:0] quotient_o
);

  logic [39:0] dvd_q, dvd_d;
  logic [19:0] rem_q, rem_d;
  logic [19:0] dsr_q, dsr_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  logic [20:0] rem_n;
  logic [20:0] diff;

  always_comb begin
    rem_n  = {rem_q, dvd_q[39]};
    diff   = rem_n - {1'b0, dsr_q};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = 6'd39;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_n >= {1'b0, dsr_q}) begin
        rem_d = diff[19:0];
        dvd_d = {dvd_q[38:0], 1'b1};
      end else begin
        rem_d = rem_n[19:0];
        dvd_d = {dvd_q[38:0], 1'b0};
      end
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

@@ rtl/particle_motion_step.sv @@
`timescale 1ns / 1ps
// A load item goes straight to the result. A step item runs the force, drag and squaring
// steps per axis (no velocity update with zero inverse mass), the square root when the
// velocity is nonzero, and the speed clamp and a respawn when they act.
// Throughput: one item at a time; the next is taken in the cycle after the result transfer,
// so the shared multiplier, the 20-step square root and the 40-step divider set the pace.
// Reset: asynchronous, active low; position and velocity clear, config registers reset.
// ----------------------------------------------------------------------------
// particle_motion_step
// Semi-implicit Euler integrator for one particle with drag, speed clamp and box
// boundary handling, sequenced around one shared multiplier.
// ----------------------------------------------------------------------------
module particle_motion_step (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // force_x, force_y, force_z, rand_frac_x, rand_frac_y, rand_frac_z,
  // load_x, load_y, load_z
  input  logic [167:0] s_axis_tdata_i,
  // req_type
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // pos_out_x, pos_out_y, pos_out_z, vel_out_x, vel_out_y, vel_out_z
  output logic [119:0] m_axis_tdata_o,
  // boundary_event
  output logic [1:0]   m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [59:0]  cfg_data_i
);

  // Configuration registers.
  logic [59:0] box_lo_q, box_hi_q;
  logic [1:0]  mode_q;
  logic [15:0] drag_q;
  logic [39:0] speed_q;
  logic [23:0] inv_mass_q;
  logic [15:0] tstep_q;

  pms_pkg::state_e state_q, state_d;
  logic [1:0]      ax_q, ax_d;
  pms_pkg::coord_t pos_q [3];
  pms_pkg::coord_t pos_d [3];
  pms_pkg::coord_t vel_q [3];
  pms_pkg::coord_t vel_d [3];
  pms_pkg::coord_t force_q [3];
  pms_pkg::coord_t force_d [3];
  logic [15:0]     frac_q [3];
  logic [15:0]     frac_d [3];
  logic signed [53:0] prod_q, prod_d;
  logic [39:0]     sumsq_q, sumsq_d;
  logic [19:0]     num_q, num_d;
  logic [19:0]     mag_q, mag_d;
  logic [1:0]      event_q, event_d;

  pms_pkg::coord_t lo [3];
  pms_pkg::coord_t hi [3];

  logic signed [28:0] mul_a;
  logic signed [24:0] mul_b;

  logic        sqrt_start, sqrt_done;
  logic [19:0] sqrt_root;
  logic        div_start, div_done;
  logic [39:0] div_quot;

  logic [19:0] vmin, vmax;
  assign vmin = speed_q[19:0];
  assign vmax = speed_q[39:20];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_lo_q   <= '0;
      box_hi_q   <= '0;
      mode_q     <= '0;
      drag_q     <= '0;
      speed_q    <= '0;
      inv_mass_q <= 24'd65536;
      tstep_q    <= 16'd1092;
    end else if (cfg_valid_i) begin
      unique case (pms_pkg::cfg_e'(cfg_index_i))
        pms_pkg::CFG_BOX_LOW:   box_lo_q   <= cfg_data_i;
        pms_pkg::CFG_BOX_HIGH:  box_hi_q   <= cfg_data_i;
        pms_pkg::CFG_BOUNDS:    mode_q     <= cfg_data_i[1:0];
        pms_pkg::CFG_DRAG:      drag_q     <= cfg_data_i[15:0];
        pms_pkg::CFG_SPEED:     speed_q    <= cfg_data_i[39:0];
        pms_pkg::CFG_INV_MASS:  inv_mass_q <= cfg_data_i[23:0];
        pms_pkg::CFG_TIME_STEP: tstep_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo[k] = box_lo_q[k*20 +: 20];
      hi[k] = box_hi_q[k*20 +: 20];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      pms_pkg::ST_ACC: begin
        mul_a = 29'(force_q[ax_q]);
        mul_b = $signed({1'b0, inv_mass_q});
      end
      pms_pkg::ST_DV: begin
        mul_a = 29'($signed(prod_q[43:16]));
        mul_b = 25'($signed({1'b0, tstep_q}));
      end
      pms_pkg::ST_DRAG: begin
        mul_a = 29'(vel_q[ax_q]);
        mul_b = 25'($signed({1'b0, 17'h10000 - {1'b0, drag_q}}));
      end
      pms_pkg::ST_SQ: begin
        mul_a = 29'(vel_q[ax_q]);
        mul_b = 25'(vel_q[ax_q]);
      end
      pms_pkg::ST_SCMUL: begin
        mul_a = 29'($signed({1'b0, mag_q}));
        mul_b = 25'($signed({1'b0, num_q}));
      end
      pms_pkg::ST_POS: begin
        mul_a = 29'(vel_q[ax_q]);
        mul_b = 25'($signed({1'b0, tstep_q}));
      end
      pms_pkg::ST_RSP: begin
        mul_a = 29'(hi[ax_q]) - 29'(lo[ax_q]);
        mul_b = 25'($signed({1'b0, frac_q[ax_q]}));
      end
      default: ;
    endcase
  end

  always_comb begin
    logic signed [22:0] s, p1, p2;
    logic               in_box;
    pms_pkg::coord_t    np, nv, v;
    logic [19:0]        mg;

    state_d    = state_q;
    ax_d       = ax_q;
    pos_d      = pos_q;
    vel_d      = vel_q;
    force_d    = force_q;
    frac_d     = frac_q;
    prod_d     = prod_q;
    sumsq_d    = sumsq_q;
    num_d      = num_q;
    mag_d      = mag_q;
    event_d    = event_q;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    in_box     = 1'b1;
    s  = '0;
    p1 = '0;
    p2 = '0;
    np = '0;
    nv = '0;
    v  = vel_q[ax_q];
    mg = v[19] ? 20'(-v) : 20'(v);

    unique case (state_q)
      pms_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          event_d = pms_pkg::EV_INSIDE;
          for (int k = 0; k < 3; k++) begin
            force_d[k] = s_axis_tdata_i[k*20 +: 20];
            frac_d[k]  = s_axis_tdata_i[60 + k*16 +: 16];
          end
          unique case (pms_pkg::req_e'(s_axis_tuser_i))
            pms_pkg::REQ_STEP: begin
              ax_d    = '0;
              sumsq_d = '0;
              state_d = pms_pkg::ST_ACC;
            end
            pms_pkg::REQ_LOAD_POS: begin
              for (int k = 0; k < 3; k++) pos_d[k] = s_axis_tdata_i[108 + k*20 +: 20];
              state_d = pms_pkg::ST_OUT;
            end
            pms_pkg::REQ_LOAD_VEL: begin
              for (int k = 0; k < 3; k++) vel_d[k] = s_axis_tdata_i[108 + k*20 +: 20];
              state_d = pms_pkg::ST_OUT;
            end
            default: state_d = pms_pkg::ST_OUT;
          endcase
        end
      end
      pms_pkg::ST_ACC: begin
        prod_d  = 54'(mul_a * mul_b);
        state_d = (inv_mass_q != '0) ? pms_pkg::ST_DV : pms_pkg::ST_DRAG;
      end
      pms_pkg::ST_DV: begin
        prod_d  = 54'(mul_a * mul_b);
        state_d = pms_pkg::ST_VADD;
      end
      pms_pkg::ST_VADD: begin
        vel_d[ax_q] = pms_pkg::sat_coord(32'(vel_q[ax_q]) + 32'($signed(prod_q[43:16])));
        state_d     = pms_pkg::ST_DRAG;
      end
      pms_pkg::ST_DRAG: begin
        prod_d  = 54'(mul_a * mul_b);
        state_d = pms_pkg::ST_DRAGW;
      end
      pms_pkg::ST_DRAGW: begin
        vel_d[ax_q] = prod_q[35:16];
        state_d     = pms_pkg::ST_SQ;
      end
      pms_pkg::ST_SQ: begin
        prod_d  = 54'(mul_a * mul_b);
        state_d = pms_pkg::ST_SQACC;
      end
      pms_pkg::ST_SQACC: begin
        sumsq_d = sumsq_q + prod_q[39:0];
        if (ax_q == 2'd2) begin
          ax_d = '0;
          if (sumsq_d == '0) begin
            state_d = pms_pkg::ST_POS;
          end else begin
            sqrt_start = 1'b1;
            state_d    = pms_pkg::ST_SQRT;
          end
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = pms_pkg::ST_ACC;
        end
      end
      pms_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          // When the two limits cross, the maximum wins if the root exceeds it, else the minimum.
          if (sqrt_root > vmax) begin
            num_d   = vmax;
            state_d = pms_pkg::ST_SCMUL;
          end else if (sqrt_root < vmin) begin
            num_d   = vmin;
            state_d = pms_pkg::ST_SCMUL;
          end else begin
            state_d = pms_pkg::ST_POS;
          end
          mag_d = mg;
        end
      end
      pms_pkg::ST_SCMUL: begin
        prod_d  = 54'(mul_a * mul_b);
        state_d = pms_pkg::ST_DIVS;
      end
      pms_pkg::ST_DIVS: begin
        div_start = 1'b1;
        state_d   = pms_pkg::ST_DIV;
      end
      pms_pkg::ST_DIV: begin
        if (div_done) begin
          if (v[19]) begin
            vel_d[ax_q] = (div_quot > 40'h80000) ? pms_pkg::CoordMin
                                                 : -$signed(div_quot[19:0]);
          end else begin
            vel_d[ax_q] = (div_quot > 40'h7FFFF) ? pms_pkg::CoordMax
                                                 : $signed(div_quot[19:0]);
          end
          if (ax_q == 2'd2) begin
            ax_d    = '0;
            state_d = pms_pkg::ST_POS;
          end else begin
            ax_d    = ax_q + 2'd1;
            v       = vel_q[ax_q + 2'd1];
            mag_d   = v[19] ? 20'(-v) : 20'(v);
            state_d = pms_pkg::ST_SCMUL;
          end
        end
      end
      pms_pkg::ST_POS: begin
        prod_d  = 54'(mul_a * mul_b);
        state_d = pms_pkg::ST_PADD;
      end
      pms_pkg::ST_PADD: begin
        pos_d[ax_q] = pms_pkg::sat_coord(32'(pos_q[ax_q]) + 32'($signed(prod_q[35:16])));
        if (ax_q == 2'd2) begin
          ax_d    = '0;
          state_d = pms_pkg::ST_BND;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = pms_pkg::ST_POS;
        end
      end
      pms_pkg::ST_BND: begin
        for (int k = 0; k < 3; k++) begin
          if (pos_q[k] < lo[k] || pos_q[k] > hi[k]) in_box = 1'b0;
        end
        state_d = pms_pkg::ST_OUT;
        if (!in_box) begin
          unique case (pms_pkg::mode_e'(mode_q))
            pms_pkg::MODE_WRAP: begin
              event_d = pms_pkg::EV_WRAP;
              for (int k = 0; k < 3; k++) begin
                s  = 23'(hi[k]) - 23'(lo[k]);
                p1 = (pos_q[k] < lo[k]) ? 23'(pos_q[k]) + s : 23'(pos_q[k]);
                p2 = (p1 > 23'(hi[k])) ? p1 - s : p1;
                pos_d[k] = pms_pkg::sat_coord(32'(p2));
              end
            end
            pms_pkg::MODE_BOUNCE: begin
              event_d = pms_pkg::EV_BOUNCE;
              for (int k = 0; k < 3; k++) begin
                np = pos_q[k];
                nv = vel_q[k];
                if (np < lo[k]) begin
                  np = lo[k];
                  nv = pms_pkg::neg_sat(nv);
                end
                if (np > hi[k]) begin
                  np = hi[k];
                  nv = pms_pkg::neg_sat(nv);
                end
                pos_d[k] = np;
                vel_d[k] = nv;
              end
            end
            pms_pkg::MODE_RESPAWN: begin
              event_d = pms_pkg::EV_RESPAWN;
              ax_d    = '0;
              state_d = pms_pkg::ST_RSP;
            end
            default: ;
          endcase
        end
      end
      pms_pkg::ST_RSP: begin
        prod_d  = 54'(mul_a * mul_b);
        state_d = pms_pkg::ST_RSPW;
      end
      pms_pkg::ST_RSPW: begin
        pos_d[ax_q] = pms_pkg::sat_coord(32'(lo[ax_q]) + 32'($signed(prod_q[36:16])));
        vel_d[ax_q] = '0;
        if (ax_q == 2'd2) begin
          ax_d    = '0;
          state_d = pms_pkg::ST_OUT;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = pms_pkg::ST_RSP;
        end
      end
      pms_pkg::ST_OUT: begin
        if (m_axis_tready_i) state_d = pms_pkg::ST_IDLE;
      end
      default: state_d = pms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pms_pkg::ST_IDLE;
      ax_q    <= '0;
      event_q <= '0;
      for (int k = 0; k < 3; k++) begin
        pos_q[k] <= '0;
        vel_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
      event_q <= event_d;
      pos_q   <= pos_d;
      vel_q   <= vel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    force_q <= force_d;
    frac_q  <= frac_d;
    prod_q  <= prod_d;
    sumsq_q <= sumsq_d;
    num_q   <= num_d;
    mag_q   <= mag_d;
  end

  pms_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sumsq_d),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  pms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q[39:0]),
    .divisor_i  (sqrt_root),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign s_axis_tready_o = (state_q == pms_pkg::ST_IDLE);
  assign m_axis_tvalid_o = (state_q == pms_pkg::ST_OUT);
  assign m_axis_tdata_o  = {vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};
  assign m_axis_tuser_o  = event_q;

endmodule

@@ bench/particle_motion_step_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_motion_step_tb
// Drives step, load and idle items through the particle integrator under several
// box, drag, speed and mass settings, predicts every result in fixed point and
// compares each returned position, velocity and boundary event in order.
// ----------------------------------------------------------------------------
module particle_motion_step_tb;

  localparam int unsigned IdleLimit = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [167:0] s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [119:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [59:0]  cfg_data_i = '0;

  typedef struct packed {
    logic [1:0]   ev;
    logic [119:0] state;
  } motion_t;

  motion_t motion_q[$];
  int      n_errors = 0;
  int      idle_cycles = 0;
  int      rx_hold = 0;
  int      rx_wait = 0;
  bit      rx_random = 1'b1;

  // Predicted block state and configuration.
  logic [59:0] box_lo, box_hi;
  logic [1:0]  bnd_mode;
  logic [15:0] drag, dt;
  logic [39:0] speeds;
  logic [23:0] inv_mass;
  longint      pos[3], vel[3];

  pms_pkg::mode_e bnd_mode_list[4] = '{pms_pkg::MODE_WRAP, pms_pkg::MODE_BOUNCE,
                                       pms_pkg::MODE_RESPAWN, pms_pkg::MODE_NONE};

  particle_motion_step DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint sext20(logic [19:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint sat20(longint v);
    if (v > longint'(pms_pkg::CoordMax)) return longint'(pms_pkg::CoordMax);
    if (v < longint'(pms_pkg::CoordMin)) return longint'(pms_pkg::CoordMin);
    return v;
  endfunction

  function automatic longint floor16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint root_floor(longint x);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - r - b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint scale_speed(longint v, longint num, longint den);
    longint q;
    q = ((v < 0) ? -v : v) * num / den;
    if (v < 0) begin
      return (q > longint'(pms_pkg::CoordMax) + 1) ? longint'(pms_pkg::CoordMin) : -q;
    end
    return (q > longint'(pms_pkg::CoordMax)) ? longint'(pms_pkg::CoordMax) : q;
  endfunction

  function automatic motion_t advance_particle(logic [1:0] kind, logic [167:0] d);
    motion_t r;
    logic [1:0] ev;
    longint lo[3], hi[3], v, acc, sumsq, m, vmin, vmax, p, frac;
    bit in_box;
    ev = pms_pkg::EV_INSIDE;
    if (kind == pms_pkg::REQ_LOAD_POS) begin
      for (int i = 0; i < 3; i++) pos[i] = sext20(d[108 + 20 * i +: 20]);
    end else if (kind == pms_pkg::REQ_LOAD_VEL) begin
      for (int i = 0; i < 3; i++) vel[i] = sext20(d[108 + 20 * i +: 20]);
    end else if (kind == pms_pkg::REQ_STEP) begin
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        v = vel[i];
        if (inv_mass != 0) begin
          acc = floor16(sext20(d[20 * i +: 20]) * longint'(inv_mass));
          v = sat20(v + floor16(acc * longint'(dt)));
        end
        v = floor16(v * (65536 - longint'(drag)));
        vel[i] = v;
        sumsq += v * v;
      end
      if (sumsq != 0) begin
        m = root_floor(sumsq);
        vmin = longint'(speeds[19:0]);
        vmax = longint'(speeds[39:20]);
        if (m > vmax) begin
          for (int i = 0; i < 3; i++) vel[i] = scale_speed(vel[i], vmax, m);
        end else if (m < vmin) begin
          for (int i = 0; i < 3; i++) vel[i] = scale_speed(vel[i], vmin, m);
        end
      end
      in_box = 1'b1;
      for (int i = 0; i < 3; i++) begin
        pos[i] = sat20(pos[i] + floor16(vel[i] * longint'(dt)));
        lo[i] = sext20(box_lo[20 * i +: 20]);
        hi[i] = sext20(box_hi[20 * i +: 20]);
        if (pos[i] < lo[i] || pos[i] > hi[i]) in_box = 1'b0;
      end
      if (!in_box) begin
        case (bnd_mode)
          pms_pkg::MODE_WRAP: begin
            ev = pms_pkg::EV_WRAP;
            for (int i = 0; i < 3; i++) begin
              p = pos[i];
              if (p < lo[i]) p += hi[i] - lo[i];
              if (p > hi[i]) p -= hi[i] - lo[i];
              pos[i] = sat20(p);
            end
          end
          pms_pkg::MODE_BOUNCE: begin
            ev = pms_pkg::EV_BOUNCE;
            for (int i = 0; i < 3; i++) begin
              if (pos[i] < lo[i]) begin
                pos[i] = lo[i];
                vel[i] = sat20(-vel[i]);
              end
              if (pos[i] > hi[i]) begin
                pos[i] = hi[i];
                vel[i] = sat20(-vel[i]);
              end
            end
          end
          pms_pkg::MODE_RESPAWN: begin
            ev = pms_pkg::EV_RESPAWN;
            for (int i = 0; i < 3; i++) begin
              frac = longint'(d[60 + 16 * i +: 16]);
              pos[i] = sat20(lo[i] + floor16((hi[i] - lo[i]) * frac));
              vel[i] = 0;
            end
          end
          default: ;
        endcase
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.state[20 * i +: 20] = pos[i][19:0];
      r.state[60 + 20 * i +: 20] = vel[i][19:0];
    end
    r.ev = ev;
    return r;
  endfunction

  task automatic write_reg(pms_pkg::cfg_e idx, logic [59:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      pms_pkg::CFG_BOX_LOW:   box_lo = val;
      pms_pkg::CFG_BOX_HIGH:  box_hi = val;
      pms_pkg::CFG_BOUNDS:    bnd_mode = val[1:0];
      pms_pkg::CFG_DRAG:      drag = val[15:0];
      pms_pkg::CFG_SPEED:     speeds = val[39:0];
      pms_pkg::CFG_INV_MASS:  inv_mass = val[23:0];
      pms_pkg::CFG_TIME_STEP: dt = val[15:0];
      default: ;
    endcase
  endtask

  // Stops offering input, waits until the block has returned everything, then lets it settle.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // With no gap, valid stays high and the next item follows the transfer directly.
  task automatic send_item(logic [1:0] kind, logic [167:0] d, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    motion_q = {motion_q, advance_particle(kind, d)};
  endtask

  function automatic logic [19:0] rand_coord(bit edgy);
    if (edgy) begin
      case ($urandom_range(0, 3))
        0: return 20'h7FFFF;
        1: return 20'h80000;
        2: return 20'h0;
        default: return 20'hFFFFF;
      endcase
    end
    return 20'($urandom);
  endfunction

  function automatic logic [167:0] rand_payload(int force_range, bit edgy);
    logic [167:0] d;
    d = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    for (int i = 0; i < 3; i++) begin
      if (edgy) d[20 * i +: 20] = rand_coord(1'b1);
      else d[20 * i +: 20] = 20'($signed($urandom_range(0, 2 * force_range)) - force_range);
      d[108 + 20 * i +: 20] = rand_coord(edgy);
    end
    return d;
  endfunction

  function automatic logic [59:0] pack3(int x, int y, int z);
    return {20'(z), 20'(y), 20'(x)};
  endfunction

  task automatic test_directed();
    logic [167:0] d;
    write_reg(pms_pkg::CFG_BOX_LOW, pack3(-40000, -40000, -40000));
    write_reg(pms_pkg::CFG_BOX_HIGH, pack3(40000, 40000, 40000));
    write_reg(pms_pkg::CFG_SPEED, 60'({20'd200000, 20'd0}));
    send_item(pms_pkg::REQ_STEP, '0);
    send_item(pms_pkg::REQ_NONE, '1);
    d = '0;
    d[0 +: 60] = pack3(524287, -524288, 1000);
    send_item(pms_pkg::REQ_STEP, d);
    d[108 +: 60] = pack3(524287, -524288, 0);
    send_item(pms_pkg::REQ_LOAD_POS, d);
    send_item(pms_pkg::REQ_LOAD_VEL, d);
    send_item(pms_pkg::REQ_STEP, d);
    d = '1;
    send_item(pms_pkg::REQ_LOAD_VEL, d);
    send_item(pms_pkg::REQ_STEP, d);
    drain();
    foreach (bnd_mode_list[k]) begin
      write_reg(pms_pkg::CFG_BOUNDS, 60'(bnd_mode_list[k]));
      d = '0;
      d[60 +: 48] = {16'hFFFF, 16'h0, 16'h8000};
      d[108 +: 60] = pack3(39000, -39000, 0);
      send_item(pms_pkg::REQ_LOAD_POS, d);
      d[108 +: 60] = pack3(50000, -50000, 3000);
      send_item(pms_pkg::REQ_LOAD_VEL, d);
      send_item(pms_pkg::REQ_STEP, d);
      send_item(pms_pkg::REQ_STEP, d);
      drain();
    end
  endtask

  // One random phase: registers set, then a burst of mostly step items.
  task automatic test_random_phase(int items, int force_range);
    logic [4:0] kind;
    drain();
    write_reg(pms_pkg::CFG_BOX_LOW, pack3(-$urandom_range(0, 300000),
                                          -$urandom_range(0, 300000),
                                          -$urandom_range(0, 524288)));
    write_reg(pms_pkg::CFG_BOX_HIGH,
              ($urandom_range(0, 7) == 0) ? 60'($urandom) << 28 ^ 60'($urandom)
              : pack3($urandom_range(0, 300000), $urandom_range(0, 300000),
                      $urandom_range(0, 524287)));
    write_reg(pms_pkg::CFG_BOUNDS, 60'($urandom_range(0, 3)));
    write_reg(pms_pkg::CFG_DRAG,
              ($urandom_range(0, 5) == 0) ? 60'hFFFF : 60'($urandom_range(0, 3000)));
    write_reg(pms_pkg::CFG_SPEED,
              60'({20'($urandom_range(0, 1) ? 20'hFFFFF : 20'($urandom)),
                   20'($urandom_range(0, 60000))}));
    write_reg(pms_pkg::CFG_INV_MASS, ($urandom_range(0, 5) == 0) ? 60'(0)
              : ($urandom_range(0, 5) == 0) ? 60'hFFFFFF : 60'($urandom_range(1, 400000)));
    write_reg(pms_pkg::CFG_TIME_STEP, ($urandom_range(0, 7) == 0) ? 60'hFFFF
              : 60'($urandom_range(0, 6000)));
    for (int n = 0; n < items; n++) begin
      kind = 5'($urandom_range(0, 19));
      if (kind < 15) begin
        send_item(pms_pkg::REQ_STEP, rand_payload(force_range, $urandom_range(0, 15) == 0));
      end else if (kind < 17) begin
        send_item(pms_pkg::REQ_LOAD_POS, rand_payload(force_range, kind[0]));
      end else if (kind < 19) begin
        send_item(pms_pkg::REQ_LOAD_VEL, rand_payload(force_range, 1'b0));
      end else begin
        send_item(pms_pkg::REQ_NONE, rand_payload(force_range, 1'b0));
      end
    end
  endtask

  // The receiver stops for a long stretch while items keep coming.
  task automatic test_backpressure();
    drain();
    rx_hold = 400;
    for (int n = 0; n < 12; n++) begin
      send_item(pms_pkg::REQ_STEP, rand_payload(20000, 1'b0), 1'b0);
    end
  endtask

  // Result side: after each transfer the receiver waits a drawn number of cycles.
  always @(posedge clk_i) begin
    int w;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      w = rx_random ? $urandom_range(0, 8) : 0;
      rx_wait <= w;
      m_axis_tready_i <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready_i <= (rx_wait == 1);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    motion_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (motion_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h/%h", $time,
                 m_axis_tdata_o, m_axis_tuser_o);
        n_errors++;
      end else begin
        want = motion_q.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (m_axis_tdata_o[20 * i +: 20] !== want.state[20 * i +: 20]) begin
            $display("%0t field %0d (pos x,y,z vel x,y,z) expected %0d actual %0d", $time, i,
                     $signed(want.state[20 * i +: 20]), $signed(m_axis_tdata_o[20 * i +: 20]));
            n_errors++;
          end
        end
        if (m_axis_tuser_o !== want.ev) begin
          $display("%0t boundary event expected %0d actual %0d", $time, want.ev,
                   m_axis_tuser_o);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    box_lo = '0;
    box_hi = '0;
    bnd_mode = pms_pkg::MODE_WRAP;
    drag = '0;
    speeds = '0;
    inv_mass = 24'd65536;
    dt = 16'd1092;
    for (int i = 0; i < 3; i++) begin
      pos[i] = 0;
      vel[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    for (int k = 0; k < 14; k++) test_random_phase(120, (k % 3 == 0) ? 524287 : 30000);
    test_backpressure();
    rx_random = 1'b0;
    test_random_phase(60, 5000);
    drain();
    repeat (200) @(posedge clk_i);
    if (n_errors == 0 && motion_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pms_pkg.sv
rtl/pms_isqrt.sv
rtl/pms_div.sv
rtl/particle_motion_step.sv
bench/particle_motion_step_tb.sv
